FILE: rtl/core/hgw_pkg.sv
// shared types and constants for the hue/green window pixel classifier
// used by every module under rtl/core; depends on nothing
package hgw_pkg;

  localparam int unsigned PIX_W     = 8;   // width of one color channel
  localparam int unsigned HUE_W     = 8;   // width of the hue value
  localparam int unsigned CFG_IDX_W = 8;   // width of the register index
  localparam int unsigned CFG_DAT_W = 8;   // width of the register data

  // divider geometry: 17-bit dividend, 9-bit divisor (2*d), 8-bit quotient
  localparam int unsigned REM_W         = 17;
  localparam int unsigned DVS_W         = 9;
  localparam int unsigned QUO_W         = 8;
  localparam int unsigned DIV_STEP_BITS = 2;
  localparam int unsigned DIV_STEPS     = QUO_W / DIV_STEP_BITS;

  // hue folding constants
  localparam logic [QUO_W:0] HUE_OFFSET = 9'd30;   // spread offset removed
  localparam logic [QUO_W:0] HUE_WRAP   = 9'd150;  // 180 - 30 for negative hue
  localparam logic [QUO_W:0] HUE_RANGE  = 9'd180;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_LOW  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_HIGH = 8'd3;

  // register reset values
  localparam logic [CFG_DAT_W-1:0] RST_HUE_LOW    = 8'd0;
  localparam logic [CFG_DAT_W-1:0] RST_HUE_HIGH   = 8'd180;
  localparam logic [CFG_DAT_W-1:0] RST_GREEN_LOW  = 8'd0;
  localparam logic [CFG_DAT_W-1:0] RST_GREEN_HIGH = 8'd255;

  // item in flight through the divider stages
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DVS_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
    logic             grey;
    logic [PIX_W-1:0] green;
  } div_item_t;

  // window bounds handed to the last stage
  typedef struct packed {
    logic [HUE_W-1:0] hue_low;
    logic [HUE_W-1:0] hue_high;
    logic [PIX_W-1:0] green_low;
    logic [PIX_W-1:0] green_high;
  } win_cfg_t;

endpackage

FILE: rtl/core/hue_green_window_pixel_mask_top.sv
// top level of the hue/green window pixel classifier
// depends on hgw_pkg, hgw_front, hgw_div_step, hgw_window
//
//   channel  signals                               direction  handshake
//   pixel    in_valid in_stall blue green red      in         valid/stall
//   result   out_valid out_stall mask hue_pass     out        valid/stall
//            green_pass hue_value
//   config   cfg_valid cfg_ready cfg_index cfg_data in        valid/ready
//
// one pixel per cycle sustained while the result is not stalled; the pipe is a front stage, four
// divider stages of two quotient bits each and a window/output stage.
// the whole pipe advances together and holds while the result is stalled.
// synchronous reset clears the valid bits and loads the register defaults.
// config writes are always ready; indexes beyond the list are dropped.
module hue_green_window_pixel_mask_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hgw_pkg::PIX_W-1:0]     blue,
  input  logic [hgw_pkg::PIX_W-1:0]     green,
  input  logic [hgw_pkg::PIX_W-1:0]     red,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          mask,
  output logic                          hue_pass,
  output logic                          green_pass,
  output logic [hgw_pkg::HUE_W-1:0]     hue_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hgw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hgw_pkg::CFG_DAT_W-1:0] cfg_data
);

  logic                 en;
  hgw_pkg::win_cfg_t    cfg;
  logic                 stg_vld  [0:hgw_pkg::DIV_STEPS];
  hgw_pkg::div_item_t   stg_item [0:hgw_pkg::DIV_STEPS];

  // pipe advances unless a finished result is held
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hue_low    <= hgw_pkg::RST_HUE_LOW;
      cfg.hue_high   <= hgw_pkg::RST_HUE_HIGH;
      cfg.green_low  <= hgw_pkg::RST_GREEN_LOW;
      cfg.green_high <= hgw_pkg::RST_GREEN_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hgw_pkg::REG_HUE_LOW:    cfg.hue_low    <= cfg_data;
        hgw_pkg::REG_HUE_HIGH:   cfg.hue_high   <= cfg_data;
        hgw_pkg::REG_GREEN_LOW:  cfg.green_low  <= cfg_data;
        hgw_pkg::REG_GREEN_HIGH: cfg.green_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // spread and dividend
  hgw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (in_valid),
    .blue     (blue),
    .green    (green),
    .red      (red),
    .out_vld  (stg_vld[0]),
    .out_item (stg_item[0])
  );

  // divider chain
  for (genvar s = 0; s < hgw_pkg::DIV_STEPS; s++) begin : g_div
    hgw_div_step #(
      .STEP (s)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_vld   (stg_vld[s]),
      .in_item  (stg_item[s]),
      .out_vld  (stg_vld[s+1]),
      .out_item (stg_item[s+1])
    );
  end

  // hue folding, window tests and output register
  hgw_window u_window (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_vld     (stg_vld[hgw_pkg::DIV_STEPS]),
    .in_item    (stg_item[hgw_pkg::DIV_STEPS]),
    .cfg        (cfg),
    .out_vld    (out_valid),
    .mask       (mask),
    .hue_pass   (hue_pass),
    .green_pass (green_pass),
    .hue_value  (hue_value)
  );

  // mask is the and of both tests
  a_mask_and : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mask == (hue_pass && green_pass)))
    else $error("mask differs from the and of the pass flags");

  // hue always folded into range
  a_hue_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hue_value < 8'd180))
    else $error("hue value out of range");

  // a write to the hue low register lands
  a_cfg_write : assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index == hgw_pkg::REG_HUE_LOW))
      |=> (cfg.hue_low == $past(cfg_data)))
    else $error("hue low register not written");

  // a held result keeps the valid bit of the last divider stage frozen
  a_hold_pipe : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(stg_vld[hgw_pkg::DIV_STEPS]))
    else $error("pipe moved while the result was held");

endmodule

FILE: rtl/core/hgw_front.sv
// first stage: channel max/min, spread and the scaled dividend
// depends on hgw_pkg
module hgw_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [hgw_pkg::PIX_W-1:0] blue,
  input  logic [hgw_pkg::PIX_W-1:0] green,
  input  logic [hgw_pkg::PIX_W-1:0] red,
  output logic                     out_vld,
  output hgw_pkg::div_item_t       out_item
);

  logic [hgw_pkg::PIX_W-1:0] mx;
  logic [hgw_pkg::PIX_W-1:0] mn;
  logic [hgw_pkg::PIX_W-1:0] d;
  logic [10:0]               shifted;
  logic [hgw_pkg::REM_W-1:0] s_ext;
  logic [hgw_pkg::REM_W-1:0] t;
  hgw_pkg::div_item_t        item_next;

  // max, min and spread of the three channels
  always_comb begin
    mx = blue;
    mn = blue;
    if (green > mx) mx = green;
    if (red > mx) mx = red;
    if (green < mn) mn = green;
    if (red < mn) mn = red;
    d = mx - mn;
  end

  // numerator plus spread, never negative
  always_comb begin
    if (mx == red) begin
      shifted = 11'(green) + 11'(d) - 11'(blue);
    end else if (mx == green) begin
      shifted = 11'(blue) + (11'(d) << 1) + 11'(d) - 11'(red);
    end else begin
      shifted = 11'(red) + (11'(d) << 2) + 11'(d) - 11'(green);
    end
  end

  // dividend 60*shifted + d, divisor 2*d
  always_comb begin
    s_ext           = hgw_pkg::REM_W'(shifted);
    t               = (s_ext << 6) - (s_ext << 2) + hgw_pkg::REM_W'(d);
    item_next.rem   = t;
    item_next.dvs   = {d, 1'b0};
    item_next.quo   = '0;
    item_next.grey  = (d == '0);
    item_next.green = green;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

FILE: rtl/core/hgw_div_step.sv
// one restoring-division stage, settles two quotient bits per cycle while the pipe is enabled
// depends on hgw_pkg
module hgw_div_step #(
  parameter int unsigned STEP = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  hgw_pkg::div_item_t in_item,
  output logic               out_vld,
  output hgw_pkg::div_item_t out_item
);

  localparam int unsigned TOP_POS = hgw_pkg::QUO_W - 1 - STEP * hgw_pkg::DIV_STEP_BITS;

  hgw_pkg::div_item_t        item_next;
  logic [hgw_pkg::REM_W-1:0] trial;
  logic [2:0]                pos;

  // compare and subtract the shifted divisor, top bit first
  always_comb begin
    item_next = in_item;
    trial     = '0;
    pos       = '0;
    for (int i = 0; i < hgw_pkg::DIV_STEP_BITS; i++) begin
      pos   = 3'(TOP_POS - i);
      trial = hgw_pkg::REM_W'(in_item.dvs) << pos;
      if (item_next.rem >= trial) begin
        item_next.rem      = item_next.rem - trial;
        item_next.quo[pos] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

FILE: rtl/core/hgw_window.sv
// last stage: hue folding into 0..179 and the window tests, output register
// depends on hgw_pkg
module hgw_window (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  hgw_pkg::div_item_t        in_item,
  input  hgw_pkg::win_cfg_t         cfg,
  output logic                      out_vld,
  output logic                      mask,
  output logic                      hue_pass,
  output logic                      green_pass,
  output logic [hgw_pkg::HUE_W-1:0] hue_value
);

  logic [hgw_pkg::QUO_W:0]   q;
  logic [hgw_pkg::QUO_W:0]   h_fold;
  logic [hgw_pkg::HUE_W-1:0] h;
  logic                      hp;
  logic                      gp;

  // remove the spread offset, negative hue wraps by 180
  always_comb begin
    q = {1'b0, in_item.quo};
    if (q >= hgw_pkg::HUE_OFFSET) begin
      h_fold = q - hgw_pkg::HUE_OFFSET;
    end else begin
      h_fold = q + hgw_pkg::HUE_WRAP;
    end
    if (h_fold >= hgw_pkg::HUE_RANGE) begin
      h_fold = h_fold - hgw_pkg::HUE_RANGE;
    end
    if (in_item.grey) begin
      h = '0;
    end else begin
      h = h_fold[hgw_pkg::HUE_W-1:0];
    end
  end

  // window tests, hue window wraps when low exceeds high
  always_comb begin
    if (cfg.hue_high >= cfg.hue_low) begin
      hp = (h >= cfg.hue_low) && (h <= cfg.hue_high);
    end else begin
      hp = (h >= cfg.hue_low) || (h <= cfg.hue_high);
    end
    gp = (in_item.green >= cfg.green_low) && (in_item.green <= cfg.green_high);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mask       <= hp && gp;
      hue_pass   <= hp;
      green_pass <= gp;
      hue_value  <= h;
    end
  end

endmodule
